// File: src/cpr_pkg.sv
// shared types and constants for the constrained path rank unit
// no dependencies; imported by every module of the block
package cpr_pkg;

   localparam int MAX_POSITIONS_DEF = 10;
   localparam int CODE_W   = 20;
   localparam int POS_W    = 4;
   localparam int RANK_W   = 16;
   localparam int HEIGHT_W = 6;
   localparam int WIDTH_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [1:0] {
      OP_RANK_MAIN  = 2'd0,
      OP_RANK_BLOCK = 2'd1,
      OP_DROP       = 2'd2,
      OP_INSERT     = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATH_WIDTH    = 3'd0,
      REG_MAIN_FIXED    = 3'd1,
      REG_MAIN_OCCUPIED = 3'd2,
      REG_BLOCK_FIXED   = 3'd3,
      REG_BLOCK_OCCUPIED = 3'd4
   } reg_index_type;

   // one transaction in flight through the position stages
   typedef struct packed {
      logic                       valid;
      op_type                     op;
      logic [CODE_W-1:0]          code;
      logic [POS_W-1:0]           pos;
      logic [RANK_W-1:0]          rin;
      logic signed [HEIGHT_W-1:0] h;
      logic [RANK_W-1:0]          sum_a;
      logic [RANK_W-1:0]          sum_b;
   } item_type;

   // configuration values seen by the builder and the stages
   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic [9:0]         main_fixed;
      logic [9:0]         main_occ;
      logic [9:0]         blk_fixed;
      logic [9:0]         blk_occ;
   } cfg_type;

endpackage

// File: src/cpr_table_build.sv
// count table builder: main and block tables, one row per cycle
// depends on cpr_pkg
module cpr_table_build #(
   parameter int MAX = cpr_pkg::MAX_POSITIONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  cpr_pkg::cfg_type                cfg,
   output logic                            busy,
   output logic [MAX:0][MAX+2:0][15:0]     main_tab,
   output logic [MAX:0][MAX+2:0][15:0]     blk_tab
);
   import cpr_pkg::*;

   localparam int ROW_W = $clog2(MAX + 1);

   logic [MAX+2:0][15:0] main_ff [MAX:1];
   logic [MAX+2:0][15:0] blk_ff  [MAX:1];
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 busy_ff, busy_in;
   logic [MAX+2:0][15:0] row0;
   logic [MAX+2:0][15:0] main_prev, blk_prev, main_new, blk_new;
   logic [ROW_W-1:0]     pos;
   logic                 mf, mo, bf, bo;

   // row 0: one way to finish at height zero
   always_comb begin
      row0    = '0;
      row0[0] = 16'd1;
   end

   always_comb begin
      main_tab[0] = row0;
      blk_tab[0]  = row0;
      for (int r = 1; r <= MAX; r++) begin
         main_tab[r] = main_ff[r];
         blk_tab[r]  = blk_ff[r];
      end
   end

   // one new row from the previous one
   always_comb begin
      pos       = row_ff - ROW_W'(1);
      main_prev = (row_ff == ROW_W'(1)) ? row0 : main_ff[row_ff - ROW_W'(1)];
      blk_prev  = (row_ff == ROW_W'(1)) ? row0 : blk_ff[row_ff - ROW_W'(1)];
      mf = cfg.main_fixed[pos];
      mo = cfg.main_occ[pos];
      bf = (32'(pos) < 9) ? cfg.blk_fixed[pos] : 1'b0;
      bo = (32'(pos) < 9) ? cfg.blk_occ[pos] : 1'b0;
      main_new = '0;
      blk_new  = '0;
      for (int h = 0; h <= MAX + 1; h++) begin
         if (!mf || !mo) main_new[h] = main_new[h] + main_prev[h];
         if (!mf || mo) begin
            if (h > 0) main_new[h] = main_new[h] + main_prev[h-1];
            main_new[h] = main_new[h] + main_prev[h+1];
         end
         if (!bf || !bo) blk_new[h] = blk_new[h] + blk_prev[h];
         if (!bf || bo) begin
            if (h > 0) blk_new[h] = blk_new[h] + blk_prev[h-1];
            blk_new[h] = blk_new[h] + blk_prev[h+1];
         end
      end
      if (32'(row_ff) > 32'(cfg.width)) main_new = '0;
      if (32'(row_ff) > 32'(cfg.width) - 1) blk_new = '0;
   end

   // row sequencer, restarted by reset or a register write
   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      if (start) begin
         busy_in = 1'b1;
         row_in  = ROW_W'(1);
      end else if (busy_ff) begin
         if (row_ff == ROW_W'(MAX)) busy_in = 1'b0;
         else row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         row_ff  <= ROW_W'(1);
      end else begin
         busy_ff <= busy_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         main_ff[row_ff] <= main_new;
         blk_ff[row_ff]  <= blk_new;
      end
   end

   assign busy = busy_ff;

endmodule

// File: src/cpr_stage.sv
// one position stage of the rank pipeline
// depends on cpr_pkg; fed table rows by cpr_table_build
module cpr_stage #(
   parameter int MAX = cpr_pkg::MAX_POSITIONS_DEF,
   parameter int POS = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  cpr_pkg::cfg_type       cfg,
   input  logic [MAX+2:0][15:0]   main_row,
   input  logic [MAX+2:0][15:0]   blk_row,
   input  logic [MAX+2:0][15:0]   prev_row,
   input  cpr_pkg::item_type      item_i,
   output cpr_pkg::item_type      item_o
);
   import cpr_pkg::*;

   localparam int COLS = MAX + 3;
   localparam int IW   = $clog2(COLS);

   item_type  item_ff, item_in;
   logic [1:0] v;
   logic      active;
   logic      mf, mo, bf, bo, pf, po;

   function automatic logic [15:0] rd(input logic [MAX+2:0][15:0] row,
                                      input logic signed [HEIGHT_W-1:0] h);
      logic [15:0] res;
      res = '0;
      if (h >= 0 && 32'(h) < COLS) res = row[h[IW-1:0]];
      return res;
   endfunction

   function automatic logic [15:0] term(input logic [MAX+2:0][15:0] row,
                                        input logic f, input logic o,
                                        input logic signed [HEIGHT_W-1:0] h,
                                        input logic [1:0] s);
      logic [15:0] acc;
      acc = '0;
      if (s > 2'd0 && (!f || !o)) acc = acc + rd(row, h);
      if (s > 2'd1 && h > 0 && (!f || o)) acc = acc + rd(row, h - HEIGHT_W'(1));
      return acc;
   endfunction

   always_comb begin
      v  = item_i.code[2*POS +: 2];
      mf = cfg.main_fixed[POS];
      mo = cfg.main_occ[POS];
      bf = (POS < 9) ? cfg.blk_fixed[POS % 9] : 1'b0;
      bo = (POS < 9) ? cfg.blk_occ[POS % 9] : 1'b0;
      pf = (POS > 0) ? cfg.blk_fixed[(POS + 8) % 9] : 1'b0;
      po = (POS > 0) ? cfg.blk_occ[(POS + 8) % 9] : 1'b0;
      case (item_i.op)
         OP_RANK_MAIN:  active = POS < 32'(cfg.width);
         OP_RANK_BLOCK: active = POS < 32'(cfg.width) - 1;
         default:       active = POS < 32'(cfg.width) && POS > 32'(item_i.pos);
      endcase
      item_in = item_i;
      if (active) begin
         case (item_i.op)
            OP_RANK_MAIN:
               item_in.sum_a = item_i.sum_a + term(main_row, mf, mo, item_i.h, v);
            OP_RANK_BLOCK:
               item_in.sum_a = item_i.sum_a + term(blk_row, bf, bo, item_i.h, v);
            default: begin
               item_in.sum_a = item_i.sum_a + term(main_row, mf, mo, item_i.h, v);
               item_in.sum_b = item_i.sum_b + term(prev_row, pf, po, item_i.h, v);
            end
         endcase
         if (v == 2'd1) item_in.h = item_i.h - HEIGHT_W'(1);
         else if (v == 2'd2) item_in.h = item_i.h + HEIGHT_W'(1);
      end
   end

   // stage register, held while the output stalls
   always_ff @(posedge clock) begin
      if (reset) item_ff.valid <= 1'b0;
      else if (enable) item_ff.valid <= item_in.valid;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff.op    <= item_in.op;
         item_ff.code  <= item_in.code;
         item_ff.pos   <= item_in.pos;
         item_ff.rin   <= item_in.rin;
         item_ff.h     <= item_in.h;
         item_ff.sum_a <= item_in.sum_a;
         item_ff.sum_b <= item_in.sum_b;
      end
   end

   assign item_o = item_ff;

endmodule

// File: src/constrained_path_rank_unit.sv
// constrained path rank unit: ranks 2-bit symbol path codes among valid codes
// Usage:
//  - req channel: tuser carries the opcode (rank main, rank block, drop delta,
//    insert delta); tdata carries mate_code, position and rank_in.
//  - rsp channel: tdata carries the 16-bit rank, one transaction per request.
//  - csr channel: register writes (path width and the four masks), always ready.
//    Write only while no request is in flight.
// Timing:
//  - one position stage per symbol position, MAX stages plus the output
//    register; a new request can enter every cycle unless stalled or rebuilding.
//  - the rate is set by the stage chain, one transaction per cycle when not stalled.
// Reset and configuration:
//  - after reset and after every register write the count tables are rebuilt,
//    one row a cycle for rows 1..MAX; req_tready stays low meanwhile.
// Stall:
//  - when rsp_tready is low with a result waiting, the whole pipeline holds
//    and req_tready drops; nothing is lost or repeated.
// depends on cpr_pkg, cpr_table_build, cpr_stage
module constrained_path_rank_unit #(
   parameter int MAX = cpr_pkg::MAX_POSITIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,  // mate_code, position, rank_in
   input  logic [1:0]                    req_tuser,  // opcode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // rank_out
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cpr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cpr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cpr_pkg::*;

   logic [3:0] width_ff;
   logic [9:0] main_fixed_ff, main_occ_ff;
   logic [8:0] blk_fixed_ff, blk_occ_ff;
   cfg_type    cfg;
   logic       csr_fire, busy, enable, req_fire;
   logic [MAX:0][MAX+2:0][15:0] main_tab, blk_tab;
   item_type   chain [MAX:0];
   logic       rsp_valid_ff;
   logic [15:0] rsp_data_ff, result;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 4'd10;
         main_fixed_ff <= '0;
         main_occ_ff   <= '0;
         blk_fixed_ff  <= '0;
         blk_occ_ff    <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            REG_PATH_WIDTH:     width_ff      <= csr_wdata[3:0];
            REG_MAIN_FIXED:     main_fixed_ff <= csr_wdata;
            REG_MAIN_OCCUPIED:  main_occ_ff   <= csr_wdata;
            REG_BLOCK_FIXED:    blk_fixed_ff  <= csr_wdata[8:0];
            REG_BLOCK_OCCUPIED: blk_occ_ff    <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // effective width saturated into 2..MAX
   always_comb begin
      if (width_ff < 4'd2) cfg.width = 4'd2;
      else if (32'(width_ff) > MAX) cfg.width = 4'(MAX);
      else cfg.width = width_ff;
      cfg.main_fixed = main_fixed_ff;
      cfg.main_occ   = main_occ_ff;
      cfg.blk_fixed  = {1'b0, blk_fixed_ff};
      cfg.blk_occ    = {1'b0, blk_occ_ff};
   end

   cpr_table_build #(.MAX(MAX)) u_build (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_fire),
      .cfg      (cfg),
      .busy     (busy),
      .main_tab (main_tab),
      .blk_tab  (blk_tab)
   );

   // global advance: output register empty or being taken
   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable && !busy;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      chain[0].valid = req_fire;
      chain[0].op    = op_type'(req_tuser);
      chain[0].code  = req_tdata[19:0];
      chain[0].pos   = req_tdata[23:20];
      chain[0].rin   = req_tdata[39:24];
      chain[0].h     = HEIGHT_W'(1);
      chain[0].sum_a = '0;
      chain[0].sum_b = '0;
   end

   // stage i handles position MAX-1-i
   for (genvar i = 0; i < MAX; i++) begin : g_stage
      localparam int P = MAX - 1 - i;
      cpr_stage #(.MAX(MAX), .POS(P)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .cfg      (cfg),
         .main_row (main_tab[P]),
         .blk_row  (blk_tab[P]),
         .prev_row (blk_tab[(P + MAX) % (MAX + 1)]),
         .item_i   (chain[i]),
         .item_o   (chain[i+1])
      );
   end

   // final combine: rank ops give sum_a; drop and insert combine both prefix sums with rank_in
   always_comb begin
      case (chain[MAX].op)
         OP_DROP:   result = chain[MAX].rin + chain[MAX].sum_b - chain[MAX].sum_a;
         OP_INSERT: result = chain[MAX].rin + chain[MAX].sum_a - chain[MAX].sum_b;
         default:   result = chain[MAX].sum_a;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (enable) rsp_valid_ff <= chain[MAX].valid;
   end

   always_ff @(posedge clock) begin
      if (enable) rsp_data_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("request taken during table build");
   a_cfg_rebuild: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> busy) else $error("register write did not start a rebuild");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(chain[MAX].valid))
      else $error("pipeline moved during output stall");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("result present after reset");
`endif

endmodule
